### sv/rank_addressed_char_list_unit_macros.svh
// Assertion helpers for the list unit RTL.
`ifndef RANK_ADDRESSED_CHAR_LIST_UNIT_MACROS_SVH
`define RANK_ADDRESSED_CHAR_LIST_UNIT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RACL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define RACL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### sv/racl_pkg.sv
`timescale 1ns / 1ps
package racl_pkg;

  localparam int CAPACITY = 64;
  localparam int IW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int CMPW     = ((CW > 8) ? CW : 8) + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_GET   = 2'd2,
    OP_PRINT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_VALUE  = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_FULL   = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INS,
    CM_DEL,
    CM_ROT
  } cell_mode_e;

  typedef enum logic {
    S_IDLE,
    S_ROT
  } state_e;

  typedef struct packed {
    cell_mode_e      mode;
    logic [IW-1:0]   pos;   // insert / delete position (rank - 1)
    logic [IW-1:0]   lidx;  // index of the last occupied cell
    logic [7:0]      elem;  // byte to insert
  } cell_ctl_t;

endpackage

### sv/rank_addressed_char_list_unit.sv
`timescale 1ns / 1ps
// Rank-addressed byte list: up to CAPACITY bytes kept in order in a row of
// shifting cells, addressed by rank from 1. A command transfers when start is
// high and busy is low. Add and delete finish in the transfer cycle (no
// result unless rejected); a rejected command or a print of an empty list
// gives one result in the next cycle. Get and print rotate the occupied
// cells through the head cell, one cell per cycle, until every stored
// element has passed through it once, and busy stays high meanwhile; print
// emits one element per cycle in rank order, get emits only the element at
// its rank. Each result sits on the result ports for exactly one cycle with
// result_valid_o high and cannot be held off by the receiver; last_o marks
// the final result of a command. After reset the list is empty and no
// clearing pass is needed.
module rank_addressed_char_list_unit
  import racl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] operation_i,
  input  logic [7:0] rank_i,
  input  logic [7:0] elem_i,
  output logic       result_valid_o,
  output logic [1:0] status_o,
  output logic [7:0] value_o,
  output logic       last_o
);

  cell_ctl_t  ctl;
  logic [7:0] cell_data [CAPACITY];

  // control: rank checks, count, rotation sequencing, result register
  racl_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .rank_i         (rank_i),
    .elem_i         (elem_i),
    .head_i         (cell_data[0]),
    .ctl_o          (ctl),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

  // cell chain: cell g holds the element at rank g + 1
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [7:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    racl_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .idx_i   (IW'(g)),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

endmodule

### sv/racl_cell.sv
`timescale 1ns / 1ps
module racl_cell
  import racl_pkg::*;
(
  input  logic          clk_i,
  input  cell_ctl_t     ctl_i,
  input  logic [IW-1:0] idx_i,
  input  logic [7:0]    left_i,
  input  logic [7:0]    right_i,
  input  logic [7:0]    head_i,
  output logic [7:0]    data_o
);

  logic [7:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.mode)
      CM_INS: begin
        if (idx_i == ctl_i.pos) begin
          data_d = ctl_i.elem;
        end else if (idx_i > ctl_i.pos) begin
          data_d = left_i;
        end
      end
      CM_DEL: begin
        if (idx_i >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      CM_ROT: begin
        // head wraps around to the last occupied cell
        if (idx_i == ctl_i.lidx) begin
          data_d = head_i;
        end else begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### sv/racl_ctrl.sv
`timescale 1ns / 1ps
`include "rank_addressed_char_list_unit_macros.svh"
module racl_ctrl
  import racl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  rank_i,
  input  logic [7:0]  elem_i,
  input  logic [7:0]  head_i,
  output cell_ctl_t   ctl_o,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  value_o,
  output logic        last_o
);

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [IW-1:0]  step_q, step_d;
  logic [IW-1:0]  tgt_q, tgt_d;
  logic           get_q, get_d;
  logic           res_valid_q, res_valid_d;
  status_e        res_status_q, res_status_d;
  logic [7:0]     res_value_q, res_value_d;
  logic           res_last_q, res_last_d;

  op_e             op;
  logic            accept;
  logic [CMPW-1:0] r_w, c_w, r_m1;
  logic            bad_add, bad_pos, full, empty, rot_end;
  logic [IW-1:0]   lidx;

  assign op      = op_e'(operation_i);
  assign accept  = start && (state_q == S_IDLE);
  assign r_w     = CMPW'(rank_i);
  assign c_w     = CMPW'(count_q);
  assign r_m1    = r_w - CMPW'(1);
  assign bad_add = (r_w == '0) || (r_w > c_w + CMPW'(1));
  assign bad_pos = (r_w == '0) || (r_w > c_w);
  assign full    = (count_q == CW'(CAPACITY));
  assign empty   = (count_q == '0);
  assign lidx    = IW'(count_q - CW'(1));
  assign rot_end = (step_q == lidx);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if ((op == OP_GET && !bad_pos) || (op == OP_PRINT && !empty)) begin
            state_d = S_ROT;
          end
        end
      end
      S_ROT: begin
        if (rot_end) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    count_d      = count_q;
    step_d       = step_q;
    tgt_d        = tgt_q;
    get_d        = get_q;
    res_valid_d  = 1'b0;
    res_status_d = STAT_VALUE;
    res_value_d  = '0;
    res_last_d   = 1'b0;
    ctl_o.mode   = CM_HOLD;
    ctl_o.pos    = r_m1[IW-1:0];
    ctl_o.lidx   = lidx;
    ctl_o.elem   = elem_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          step_d = '0;
          tgt_d  = r_m1[IW-1:0];
          get_d  = (op == OP_GET);
          case (op)
            OP_ADD: begin
              if (bad_add) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_BADPOS;
                res_last_d   = 1'b1;
              end else if (full) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_FULL;
                res_last_d   = 1'b1;
              end else begin
                ctl_o.mode = CM_INS;
                count_d    = count_q + CW'(1);
              end
            end
            OP_DEL: begin
              if (bad_pos) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_BADPOS;
                res_last_d   = 1'b1;
              end else begin
                ctl_o.mode = CM_DEL;
                count_d    = count_q - CW'(1);
              end
            end
            OP_GET: begin
              if (bad_pos) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_BADPOS;
                res_last_d   = 1'b1;
              end
            end
            OP_PRINT: begin
              if (empty) begin
                res_valid_d  = 1'b1;
                res_status_d = STAT_EMPTY;
                res_last_d   = 1'b1;
              end
            end
            default: res_valid_d = 1'b0;
          endcase
        end
      end
      S_ROT: begin
        // head cell is the element at rank step_q + 1
        ctl_o.mode  = CM_ROT;
        step_d      = step_q + IW'(1);
        res_value_d = head_i;
        if (get_q) begin
          res_valid_d = (step_q == tgt_q);
          res_last_d  = 1'b1;
        end else begin
          res_valid_d = 1'b1;
          res_last_d  = rot_end;
        end
      end
      default: ctl_o.mode = CM_HOLD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q       <= step_d;
    tgt_q        <= tgt_d;
    get_q        <= get_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    res_last_q   <= res_last_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign value_o        = res_value_q;
  assign last_o         = res_last_q;

  `RACL_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
  `RACL_ASSERT(a_run_continues, (res_valid_q && !res_last_q) |-> (state_q == S_ROT),
               "print run ended without last")
  `RACL_ASSERT(a_add_counts, (accept && op == OP_ADD && !bad_add && !full) |=>
               (count_q == $past(count_q) + CW'(1)), "add did not grow count")
  `RACL_ASSERT(a_status_clean, (res_valid_q && res_status_q != STAT_VALUE) |->
               (res_value_q == '0 && res_last_q), "error result not clean")

endmodule

### tb/sv/rank_addressed_char_list_unit_test.sv
`timescale 1ns / 1ps
module rank_addressed_char_list_unit_test;
  import racl_pkg::*;

  // One queued command, with the idle cycles the sender spends before it and
  // an optional drain flag: hold the command back until no reply is due.
  typedef struct {
    op_e        op;
    logic [7:0] rank;
    logic [7:0] elem;
    int         hold_off;
    bit         drain;
  } list_cmd_t;

  // One reply the list owes us.
  typedef struct {
    status_e    status;
    logic [7:0] value;
    logic       is_last;
  } reply_t;

  // Cycles to keep watching after the last reply: a get keeps rotating the
  // cells after its reply has gone out.
  localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start  = 1'b0;
  logic       busy;
  logic [1:0] operation = OP_ADD;
  logic [7:0] rank      = 8'd0;
  logic [7:0] elem      = 8'd0;
  logic       result_valid_o;
  logic [1:0] status_o;
  logic [7:0] value_o;
  logic       last_o;

  rank_addressed_char_list_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation),
    .rank_i         (rank),
    .elem_i         (elem),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .value_o        (value_o),
    .last_o         (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Commands waiting to be sent, and replies predicted but not yet seen.
  list_cmd_t  cmd_backlog[$];
  reply_t     replies_due[$];

  // Predicted list contents, updated on every accepted transfer.
  logic [7:0] model_list[CAPACITY];
  int         model_len = 0;

  // Stimulus-side view of the list length, so random ranks land mostly in
  // range. filling steers the length up until the list has been full a
  // while, then down until it is empty again.
  int         gen_len = 0;
  bit         filling = 1'b1;

  // Handshake between the monitor (posedge) and the driver (negedge).
  bit         took_cmd = 1'b0;
  bit         holding  = 1'b0;

  int         mismatches   = 0;
  int         cmds_taken   = 0;
  int         peak_len     = 0;
  int         status_seen[4] = '{0, 0, 0, 0};

  // ---------------------------------------------------------------------------
  // Predictor: apply one accepted command to the model list and queue the
  // replies it owes.
  // ---------------------------------------------------------------------------
  function automatic void owe_reply(status_e st, logic [7:0] val, logic fin);
    reply_t r;
    r.status  = st;
    r.value   = val;
    r.is_last = fin;
    replies_due.push_back(r);
  endfunction

  function automatic void apply_list_command(op_e op, logic [7:0] rk, logic [7:0] el);
    int r;
    int i;
    r = int'(rk);
    case (op)
      OP_ADD: begin
        // rank is checked before capacity
        if (r < 1 || r > model_len + 1) begin
          owe_reply(STAT_BADPOS, 8'd0, 1'b1);
        end else if (model_len >= CAPACITY) begin
          owe_reply(STAT_FULL, 8'd0, 1'b1);
        end else begin
          for (i = model_len; i >= r; i--) model_list[i] = model_list[i-1];
          model_list[r-1] = el;
          model_len++;
          if (model_len > peak_len) peak_len = model_len;
        end
      end
      OP_DEL: begin
        if (r < 1 || r > model_len) begin
          owe_reply(STAT_BADPOS, 8'd0, 1'b1);
        end else begin
          for (i = r; i < model_len; i++) model_list[i-1] = model_list[i];
          model_len--;
        end
      end
      OP_GET: begin
        if (r < 1 || r > model_len) owe_reply(STAT_BADPOS, 8'd0, 1'b1);
        else owe_reply(STAT_VALUE, model_list[r-1], 1'b1);
      end
      default: begin
        // print: whole list in rank order, or one empty marker
        if (model_len == 0) begin
          owe_reply(STAT_EMPTY, 8'd0, 1'b1);
        end else begin
          for (i = 0; i < model_len; i++)
            owe_reply(STAT_VALUE, model_list[i], (i == model_len - 1));
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Idle run before a command: each cycle idles with probability pct percent.
  function automatic int idle_run(int pct);
    int n;
    n = 0;
    while (n < 40 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  function automatic void queue_cmd(op_e op, int rk, int el, int pct, bit drain);
    list_cmd_t c;
    c.op       = op;
    c.rank     = rk[7:0];
    c.elem     = el[7:0];
    c.hold_off = idle_run(pct);
    c.drain    = drain;
    cmd_backlog.push_back(c);
    // track the length the list will have once this command is done
    if (op == OP_ADD && rk >= 1 && rk <= gen_len + 1 && gen_len < CAPACITY) gen_len++;
    else if (op == OP_DEL && rk >= 1 && rk <= gen_len) gen_len--;
    if (gen_len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
    else if (gen_len == 0) filling = 1'b1;
  endfunction

  // Mostly in-range ranks with random payload; the rest are off the ends
  // (zero, or past the last valid rank up to 255).
  function automatic void queue_random_cmd(int pct);
    int  pick;
    int  add_w;
    int  del_w;
    int  hi;
    int  rk;
    op_e op;
    add_w = filling ? 55 : 15;
    del_w = filling ? 15 : 55;
    pick  = $urandom_range(99);
    if (pick < add_w)              op = OP_ADD;
    else if (pick < add_w + del_w) op = OP_DEL;
    else if (pick < 92)            op = OP_GET;
    else                           op = OP_PRINT;
    hi = (op == OP_ADD) ? gen_len + 1 : gen_len;
    if (op == OP_PRINT)                            rk = $urandom_range(255);
    else if ($urandom_range(99) < 85 && hi >= 1)   rk = $urandom_range(hi, 1);
    else if ($urandom_range(3) == 0 || hi >= 255)  rk = 0;
    else                                           rk = $urandom_range(255, hi + 1);
    queue_cmd(op, rk, $urandom_range(255), pct, ($urandom_range(99) < 3));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: changes inputs on the falling edge. A command stays on the bus
  // with start high until the monitor has seen it transfer.
  // ---------------------------------------------------------------------------
  list_cmd_t next_cmd;

  always @(negedge clk_i) begin
    if (took_cmd) begin
      took_cmd = 1'b0;
      holding  = 1'b0;
    end
    if (rst_ni && !holding) begin
      if (cmd_backlog.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_backlog[0].hold_off != 0) begin
        cmd_backlog[0].hold_off = cmd_backlog[0].hold_off - 1;
        start <= 1'b0;
      end else if (cmd_backlog[0].drain && replies_due.size() != 0) begin
        // let every owed reply come back before this one goes
        start <= 1'b0;
      end else begin
        next_cmd = cmd_backlog.pop_front();
        operation <= next_cmd.op;
        rank      <= next_cmd.rank;
        elem      <= next_cmd.elem;
        start     <= 1'b1;
        holding    = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, check any reply against the oldest one owed,
  // then feed a transferring command to the predictor. A reply can never
  // belong to a command that transfers on the same edge.
  // ---------------------------------------------------------------------------
  reply_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) begin
        status_seen[status_o]++;
        if (replies_due.size() == 0) begin
          $display("%0t: reply with none owed: status %0d value %0d last %0d",
                   $time, status_o, value_o, last_o);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (status_o !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, status_o);
            mismatches++;
          end
          if (value_o !== want.value) begin
            $display("%0t: value mismatch, expected %0d, got %0d",
                     $time, want.value, value_o);
            mismatches++;
          end
          if (last_o !== want.is_last) begin
            $display("%0t: last mismatch, expected %0d, got %0d",
                     $time, want.is_last, last_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_command(op_e'(operation), rank, elem);
        cmds_taken++;
        took_cmd = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed corners, then three random phases (sender idles 28%,
  // then 87%, then never), then wait for all replies and settle.
  // ---------------------------------------------------------------------------
  initial begin
    // empty list corners
    queue_cmd(OP_PRINT, 0,   8'h3c, 28, 1'b1);
    queue_cmd(OP_GET,   1,   0,     28, 1'b0);
    queue_cmd(OP_DEL,   1,   0,     28, 1'b0);
    queue_cmd(OP_ADD,   0,   8'h11, 28, 1'b0);
    queue_cmd(OP_ADD,   2,   8'h22, 28, 1'b0);
    // build A5 00 5A FF: tail, head and middle inserts, zero and 0xff bytes
    queue_cmd(OP_ADD,   1,   8'h00, 28, 1'b0);
    queue_cmd(OP_ADD,   2,   8'hff, 28, 1'b0);
    queue_cmd(OP_ADD,   1,   8'ha5, 28, 1'b0);
    queue_cmd(OP_ADD,   3,   8'h5a, 28, 1'b0);
    queue_cmd(OP_ADD,   255, 8'h77, 28, 1'b0);
    // reads: stored zero, last rank, one past the end, rank zero
    queue_cmd(OP_GET,   2,   8'hff, 28, 1'b0);
    queue_cmd(OP_GET,   4,   0,     28, 1'b0);
    queue_cmd(OP_GET,   5,   0,     28, 1'b0);
    queue_cmd(OP_GET,   0,   0,     28, 1'b0);
    queue_cmd(OP_PRINT, 255, 8'hff, 28, 1'b1);
    // deletes: out of range, middle, tail, head, down to empty
    queue_cmd(OP_DEL,   0,   0,     28, 1'b0);
    queue_cmd(OP_DEL,   5,   0,     28, 1'b0);
    queue_cmd(OP_DEL,   2,   0,     28, 1'b0);
    queue_cmd(OP_DEL,   3,   0,     28, 1'b0);
    queue_cmd(OP_DEL,   1,   0,     28, 1'b0);
    queue_cmd(OP_PRINT, 0,   0,     28, 1'b0);
    queue_cmd(OP_DEL,   1,   0,     28, 1'b0);
    queue_cmd(OP_PRINT, 0,   0,     28, 1'b0);

    for (int n = 0; n < 150; n++) queue_random_cmd(28);
    cmd_backlog[cmd_backlog.size() - 1].drain = 1'b1;
    for (int n = 0; n < 150; n++) queue_random_cmd(87);
    cmd_backlog[cmd_backlog.size() - 1].drain = 1'b1;
    for (int n = 0; n < 150; n++) queue_random_cmd(0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || holding) @(negedge clk_i);
    while (replies_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("covered %0d commands, peak list length %0d of %0d", cmds_taken,
             peak_len, CAPACITY);
    $display("replies: %0d values, %0d bad rank, %0d full, %0d empty prints",
             status_seen[STAT_VALUE], status_seen[STAT_BADPOS],
             status_seen[STAT_FULL], status_seen[STAT_EMPTY]);
    if (mismatches == 0) begin
      $display("rank_addressed_char_list_unit_test: done, clean");
    end else begin
      $display("rank_addressed_char_list_unit_test: done, errors");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("timeout: %0d commands left, %0d replies owed",
             cmd_backlog.size(), replies_due.size());
    $display("rank_addressed_char_list_unit_test: done, errors");
    $finish;
  end

endmodule
